// ----- rtl/dlts_pkg.sv -----
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants for the delta list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int unsigned MaxTasks = 32;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CntW     = 6;
  localparam int unsigned ResLimit = 32;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOT_USED = 3'd2,
    ST_DUE      = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_ADD_RD,
    FSM_INS_RD,
    FSM_INS_WALK,
    FSM_INS_LINK,
    FSM_INS_FIX,
    FSM_DEL_SET,
    FSM_UNL_RD,
    FSM_UNL_SUM,
    FSM_UNL_FIX,
    FSM_DSP_RD,
    FSM_DSP_CHK,
    FSM_DSP_NEXT,
    FSM_TICK
  } fsm_e;

  // controller -> datapath
  typedef struct packed {
    logic cap_input;   // latch input word
    logic ins_start;   // load insert walk: slot=cur_slot, delay=work delay
    logic ins_step;    // advance walk by one
    logic ins_link;    // write link fields of the new entry
    logic ins_fix;     // link neighbors, fix successor delta / head
    logic unl_read;    // read unlink neighbors
    logic unl_sum;     // read successor delta
    logic unl_fix;     // add delta to successor, relink
    logic dsp_read;    // read head entry
    logic dsp_req;     // reinsert: slot = head, delay = period
    logic tick;        // decrement head
    logic add_setup;   // claim free slot, store period
    logic del_setup;   // free target slot, cur = target
    logic free_cur;    // free cur slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic head_due;
    logic period_zero;
    logic tgt_used;
  } dp_sts_t;

endpackage

// ----- rtl/dlts_datapath.sv -----
// ----------------------------------------------------------------------------
// dlts_datapath
// Link tables, delta/period memories and list walk for the scheduler.
// ----------------------------------------------------------------------------
module dlts_datapath
  import dlts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [31:0]      delay_ticks_i,
  input  logic [31:0]      period_ticks_i,
  input  logic [SlotW-1:0] target_slot_i,
  output dp_sts_t          sts_o,
  output logic [SlotW-1:0] cur_slot_o
);

  logic [31:0]      delta_q  [MaxTasks];
  logic [31:0]      period_q [MaxTasks];
  logic [SlotW-1:0] next_q   [MaxTasks];
  logic [SlotW-1:0] prev_q   [MaxTasks];
  logic [MaxTasks-1:0] used_q, used_d;
  logic [SlotW-1:0] head_q, head_d;
  logic             ne_q, ne_d;

  logic [31:0]      dly_q, per_in_q;
  logic [SlotW-1:0] tgt_q;
  logic [SlotW-1:0] cur_q;      // slot being inserted / unlinked
  logic [SlotW-1:0] walk_q;     // walk position
  logic [CntW-1:0]  walked_q;
  logic             at_end_q;
  logic [31:0]      d_q;        // remaining delay
  logic [31:0]      wdelta_q;   // delta at walk position (registered read)
  logic [SlotW-1:0] wnext_q, wprev_q;
  logic [SlotW-1:0] un_q, up_q; // unlink neighbors
  logic [31:0]      ud_s_q, ud_n_q;
  logic [31:0]      hdelta_q, hper_q;
  logic [SlotW-1:0] free_slot;
  logic             full;
  logic [32:0]      usum;

  always_comb begin
    free_slot = '0;
    full = 1'b1;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = SlotW'(i);
        full = 1'b0;
      end
    end
  end

  assign usum = {1'b0, ud_n_q} + {1'b0, ud_s_q};

  assign sts_o.full        = full;
  assign sts_o.empty       = !ne_q;
  assign sts_o.walk_done   = at_end_q || (wdelta_q > d_q) ||
                             (walked_q == CntW'(MaxTasks));
  assign sts_o.head_due    = ne_q && (hdelta_q == '0);
  assign sts_o.period_zero = (hper_q == '0);
  assign sts_o.tgt_used    = used_q[target_slot_i];
  assign cur_slot_o        = cur_q;

  always_comb begin
    used_d = used_q;
    head_d = head_q;
    ne_d   = ne_q;
    if (cmd_i.add_setup) used_d[free_slot] = 1'b1;
    if (cmd_i.del_setup) used_d[tgt_q] = 1'b0;
    if (cmd_i.free_cur)  used_d[cur_q] = 1'b0;
    if (cmd_i.ins_start && !ne_q) begin
      head_d = cur_q;
      ne_d   = 1'b1;
    end
    if (cmd_i.ins_fix && !at_end_q && walked_q == '0) head_d = cur_q;
    if (cmd_i.unl_fix) begin
      if (un_q == cur_q) begin
        ne_d   = 1'b0;
        head_d = '0;
      end else if (cur_q == head_q) begin
        head_d = un_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      head_q <= '0;
      ne_q   <= 1'b0;
    end else begin
      used_q <= used_d;
      head_q <= head_d;
      ne_q   <= ne_d;
    end
  end

  // payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_input) begin
      dly_q    <= delay_ticks_i;
      per_in_q <= period_ticks_i;
      tgt_q    <= target_slot_i;
    end
    if (cmd_i.add_setup) begin
      cur_q <= free_slot;
      period_q[free_slot] <= per_in_q;
      d_q <= dly_q;
    end
    if (cmd_i.del_setup) cur_q <= tgt_q;
    if (cmd_i.dsp_read) begin
      hdelta_q <= delta_q[head_q];
      hper_q   <= period_q[head_q];
      cur_q    <= head_q;
    end
    if (cmd_i.dsp_req) d_q <= hper_q;
    if (cmd_i.ins_start) begin
      walk_q   <= head_q;
      walked_q <= '0;
      at_end_q <= 1'b0;
      wdelta_q <= delta_q[head_q];
      wnext_q  <= next_q[head_q];
      wprev_q  <= prev_q[head_q];
      if (!ne_q) begin
        next_q[cur_q]  <= cur_q;
        prev_q[cur_q]  <= cur_q;
        delta_q[cur_q] <= d_q;
      end
    end
    if (cmd_i.ins_step) begin
      d_q      <= d_q - wdelta_q;
      walk_q   <= wnext_q;
      walked_q <= walked_q + 1'b1;
      at_end_q <= (wnext_q == head_q);
      wdelta_q <= delta_q[wnext_q];
      wnext_q  <= next_q[wnext_q];
      wprev_q  <= prev_q[wnext_q];
    end
    // new entry first, neighbors in the next cycle
    if (cmd_i.ins_link) begin
      next_q[cur_q]  <= walk_q;
      prev_q[cur_q]  <= wprev_q;
      delta_q[cur_q] <= d_q;
    end
    if (cmd_i.ins_fix) begin
      next_q[wprev_q] <= cur_q;
      prev_q[walk_q]  <= cur_q;
      if (!at_end_q) delta_q[walk_q] <= wdelta_q - d_q;
    end
    if (cmd_i.unl_read) begin
      un_q   <= next_q[cur_q];
      up_q   <= prev_q[cur_q];
      ud_s_q <= delta_q[cur_q];
    end
    if (cmd_i.unl_sum) ud_n_q <= delta_q[un_q];
    if (cmd_i.unl_fix && un_q != cur_q) begin
      if (un_q != head_q)
        delta_q[un_q] <= usum[32] ? 32'hFFFF_FFFF : usum[31:0];
      next_q[up_q] <= un_q;
      prev_q[un_q] <= up_q;
    end
    if (cmd_i.tick && ne_q && delta_q[head_q] != '0)
      delta_q[head_q] <= delta_q[head_q] - 1'b1;
  end

endmodule

// ----- rtl/dlts_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlts_ctrl
// Sequencer for add, tick, dispatch and delete.
// ----------------------------------------------------------------------------
module dlts_ctrl
  import dlts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       command_i,
  input  logic [SlotW-1:0] target_slot_i,
  input  dp_sts_t          sts_i,
  input  logic [SlotW-1:0] cur_slot_i,
  output dp_cmd_t          cmd_o,
  output logic             busy_o,
  output logic             strobe_o,
  output logic [SlotW-1:0] result_slot_o,
  output logic [2:0]       status_o,
  output logic             is_last_o
);

  fsm_e state_q, state_d;
  cmd_e op_q, op_d;
  logic [CntW-1:0]  k_q, k_d;       // dispatch results so far
  logic [SlotW-1:0] held_q, held_d; // due slot not yet reported
  logic             str_q, str_d, last_q, last_d;
  logic [SlotW-1:0] rs_q, rs_d;
  status_e          st_q, st_d;

  assign busy_o        = (state_q != FSM_IDLE);
  assign strobe_o      = str_q;
  assign result_slot_o = rs_q;
  assign status_o      = st_q;
  assign is_last_o     = last_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    k_d     = k_q;
    held_d  = held_q;
    str_d   = 1'b0;
    last_d  = 1'b0;
    rs_d    = rs_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          cmd_o.cap_input = 1'b1;
          op_d = cmd_e'(command_i);
          k_d  = '0;
          unique case (cmd_e'(command_i))
            CMD_ADD:      state_d = FSM_ADD_RD;
            CMD_TICK:     state_d = FSM_TICK;
            CMD_DISPATCH: state_d = FSM_DSP_RD;
            CMD_DELETE: begin
              if (!sts_i.tgt_used) begin
                str_d = 1'b1; last_d = 1'b1;
                rs_d = target_slot_i; st_d = ST_NOT_USED;
                state_d = FSM_IDLE;
              end else begin
                state_d = FSM_DEL_SET;
              end
            end
            default: state_d = FSM_IDLE;
          endcase
        end
      end
      FSM_TICK: begin
        cmd_o.tick = 1'b1;
        str_d = 1'b1; last_d = 1'b1; rs_d = '0; st_d = ST_DONE;
        state_d = FSM_IDLE;
      end
      FSM_ADD_RD: begin
        if (sts_i.full) begin
          str_d = 1'b1; last_d = 1'b1; rs_d = '0; st_d = ST_FULL;
          state_d = FSM_IDLE;
        end else begin
          cmd_o.add_setup = 1'b1;
          state_d = FSM_INS_RD;
        end
      end
      FSM_INS_RD: begin
        cmd_o.ins_start = 1'b1;
        state_d = sts_i.empty ? FSM_DSP_NEXT : FSM_INS_WALK;
      end
      FSM_INS_WALK: begin
        if (sts_i.walk_done) state_d = FSM_INS_LINK;
        else cmd_o.ins_step = 1'b1;
      end
      FSM_INS_LINK: begin
        cmd_o.ins_link = 1'b1;
        state_d = FSM_INS_FIX;
      end
      FSM_INS_FIX: begin
        cmd_o.ins_fix = 1'b1;
        state_d = FSM_DSP_NEXT;
      end
      FSM_DSP_NEXT: begin
        // end of an insert, or of a freed one-shot task
        if (op_q == CMD_DISPATCH) begin
          if (k_q == CntW'(ResLimit)) begin
            str_d = 1'b1; last_d = 1'b1; rs_d = held_q; st_d = ST_DUE;
            state_d = FSM_IDLE;
          end else begin
            state_d = FSM_DSP_RD;
          end
        end else begin
          str_d = 1'b1; last_d = 1'b1; rs_d = cur_slot_i; st_d = ST_DONE;
          state_d = FSM_IDLE;
        end
      end
      FSM_DSP_RD: begin
        cmd_o.dsp_read = 1'b1;
        state_d = FSM_DSP_CHK;
      end
      FSM_DSP_CHK: begin
        if (!sts_i.head_due) begin
          // emit the held due result as last, or none due
          str_d = 1'b1; last_d = 1'b1;
          if (k_q == '0) begin
            rs_d = '0; st_d = ST_NONE_DUE;
          end else begin
            rs_d = held_q; st_d = ST_DUE;
          end
          state_d = FSM_IDLE;
        end else begin
          // previous due result goes out now, not last
          if (k_q != '0) begin
            str_d = 1'b1; rs_d = held_q; st_d = ST_DUE;
          end
          held_d = cur_slot_i;
          k_d = k_q + 1'b1;
          state_d = FSM_UNL_RD;
        end
      end
      FSM_DEL_SET: begin
        cmd_o.del_setup = 1'b1;
        state_d = FSM_UNL_RD;
      end
      FSM_UNL_RD: begin
        cmd_o.unl_read = 1'b1;
        state_d = FSM_UNL_SUM;
      end
      FSM_UNL_SUM: begin
        cmd_o.unl_sum = 1'b1;
        state_d = FSM_UNL_FIX;
      end
      FSM_UNL_FIX: begin
        cmd_o.unl_fix = 1'b1;
        if (op_q == CMD_DISPATCH) begin
          if (sts_i.period_zero) begin
            cmd_o.free_cur = 1'b1;
            state_d = FSM_DSP_NEXT;
          end else begin
            cmd_o.dsp_req = 1'b1;
            state_d = FSM_INS_RD;
          end
        end else begin
          str_d = 1'b1; last_d = 1'b1; rs_d = cur_slot_i; st_d = ST_DONE;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      op_q    <= CMD_ADD;
      k_q     <= '0;
      held_q  <= '0;
      str_q   <= 1'b0;
      last_q  <= 1'b0;
      rs_q    <= '0;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      k_q     <= k_d;
      held_q  <= held_d;
      str_q   <= str_d;
      last_q  <= last_d;
      rs_q    <= rs_d;
      st_q    <= st_d;
    end
  end

endmodule

// ----- rtl/delta_list_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Delta-list timer queue for up to 32 timed tasks.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low, one at a time: busy
// stays high until the cycle that shows the final word. Every result word is
// shown for exactly one cycle with strobe high and cannot be stalled, so the
// receiver must take it then; is_last_o marks the final word of a command.
// Add walks the list past the entries whose delta does not exceed the new
// delay, one entry per cycle and at most 31, then links the new entry in.
// Dispatch reports each due head entry in turn, frees a one-shot task and
// puts a periodic one back with its period, and stops at the first head
// that is not due or when the 32-word cap is hit.
module delta_list_task_scheduler
  import dlts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       command_i,
  input  logic [31:0]      delay_ticks_i,
  input  logic [31:0]      period_ticks_i,
  input  logic [SlotW-1:0] target_slot_i,
  output logic             strobe,
  output logic [SlotW-1:0] result_slot_o,
  output logic [2:0]       status_o,
  output logic             is_last_o
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [SlotW-1:0] cur_slot;

  dlts_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .delay_ticks_i, .period_ticks_i, .target_slot_i,
    .sts_o(sts), .cur_slot_o(cur_slot)
  );

  dlts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .command_i, .target_slot_i,
    .sts_i(sts), .cur_slot_i(cur_slot), .cmd_o(cmd),
    .busy_o(busy), .strobe_o(strobe), .result_slot_o, .status_o, .is_last_o
  );

endmodule
